[hw/rtl/plt_pkg.sv]
// Shared types, codes and constants for the page recency list tracker.
// No dependencies; every other source file but plt_ram imports this package.
package plt_pkg;

  // Page space and link encoding
  localparam int NUM_PAGES = 4096;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int LINK_W    = PAGE_W + 1;

  localparam logic [LINK_W-1:0] HEAD_MARK = LINK_W'(NUM_PAGES);
  localparam logic [LINK_W-1:0] TAIL_MARK = LINK_W'(NUM_PAGES + 1);
  localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(NUM_PAGES + 2);

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_STEP_LIMIT = 2'd1;
  localparam logic [31:0] UPDATE_INTERVAL_RST = 32'd24000;
  localparam logic [15:0] SCAN_STEP_LIMIT_RST = 16'd8192;

  // Command codes
  localparam logic [1:0] CMD_TOUCH        = 2'd0;
  localparam logic [1:0] CMD_SCAN_STEP    = 2'd1;
  localparam logic [1:0] CMD_SCAN_RESTART = 2'd2;

  // Touch status codes
  localparam logic [2:0] ST_NEW      = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_RECENT   = 3'd3;
  localparam logic [2:0] ST_NOT_USED = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] page_number;
    logic [31:0] now_time;
    logic        page_in_use;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  touch_status;
    logic [11:0] scan_page;
    logic        scan_valid;
    logic [12:0] resident_count;
  } out_item_t;

  // Link memory access
  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] waddr;
    logic [LINK_W-1:0] wdata;
    logic [PAGE_W-1:0] raddr;
  } link_req_t;

  // Time stamp memory access
  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] waddr;
    logic [31:0]       wdata;
    logic [PAGE_W-1:0] raddr;
  } time_req_t;

  typedef struct packed {
    logic [31:0] diff;
    logic        borrow;
  } alu_res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_T_CHECK,
    S_T_COMPARE,
    S_T_UNLINK,
    S_T_LINK,
    S_T_FINISH,
    S_SCAN_STEP,
    S_DONE
  } seq_state_t;

endpackage

[hw/rtl/plt_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module plt_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/plt_alu.sv]
// Shared 32-bit subtractor: time difference and limit compares.
// Depends on plt_pkg.
module plt_alu (
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output plt_pkg::alu_res_t res
);
  import plt_pkg::*;

  logic [32:0] full;

  // Subtract with borrow out; borrow set when a < b
  assign full       = {1'b0, a} - {1'b0, b};
  assign res.diff   = full[31:0];
  assign res.borrow = full[32];

endmodule

[hw/rtl/plt_seq.sv]
// Sequencer of the page recency list tracker: list pointers, scan state,
// configuration and the memory access schedule. Depends on plt_pkg.
module plt_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  plt_pkg::in_item_t           in_data,
  output logic                        in_stall,
  output logic                        out_valid,
  output plt_pkg::out_item_t          out_data,
  input  logic                        out_stall,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [plt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  output plt_pkg::link_req_t          next_req,
  output plt_pkg::link_req_t          prev_req,
  output plt_pkg::time_req_t          time_req,
  input  logic [plt_pkg::LINK_W-1:0]  next_rdata,
  input  logic [plt_pkg::LINK_W-1:0]  prev_rdata,
  input  logic [31:0]                 time_rdata,
  output logic [31:0]                 alu_a,
  output logic [31:0]                 alu_b,
  input  plt_pkg::alu_res_t           alu_res
);
  import plt_pkg::*;

  seq_state_t        state_r, state_nxt;
  logic [PAGE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [31:0]       now_r, now_nxt;
  logic              in_use_r, in_use_nxt;
  logic [LINK_W-1:0] np_r, np_nxt;
  logic [LINK_W-1:0] pp_r, pp_nxt;
  logic [31:0]       diff_r, diff_nxt;
  logic [2:0]        status_r, status_nxt;
  logic              is_new_r, is_new_nxt;
  logic [LINK_W-1:0] first_r, first_nxt;
  logic [LINK_W-1:0] last_r, last_nxt;
  logic [12:0]       count_r, count_nxt;
  logic [LINK_W-1:0] scan_pos_r, scan_pos_nxt;
  logic [15:0]       scan_steps_r, scan_steps_nxt;
  logic [31:0]       interval_r;
  logic [15:0]       limit_r;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              accept;
  logic [LINK_W-1:0] scan_pred;
  logic [16:0]       scan_cnt;

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= UPDATE_INTERVAL_RST;
      limit_r    <= SCAN_STEP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_UPDATE_INTERVAL: interval_r <= cfg_data;
        CFG_SCAN_STEP_LIMIT: limit_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      first_r      <= TAIL_MARK;
      last_r       <= HEAD_MARK;
      count_r      <= '0;
      scan_pos_r   <= TAIL_MARK;
      scan_steps_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      first_r      <= first_nxt;
      last_r       <= last_nxt;
      count_r      <= count_nxt;
      scan_pos_r   <= scan_pos_nxt;
      scan_steps_r <= scan_steps_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    page_r     <= page_nxt;
    now_r      <= now_nxt;
    in_use_r   <= in_use_nxt;
    np_r       <= np_nxt;
    pp_r       <= pp_nxt;
    diff_r     <= diff_nxt;
    status_r   <= status_nxt;
    is_new_r   <= is_new_nxt;
    out_data_r <= out_data_nxt;
  end

  // Predecessor of the scan pointer and the advanced step count
  always_comb begin
    if (scan_pos_r < HEAD_MARK) begin
      scan_pred = prev_rdata;
    end else if (scan_pos_r == TAIL_MARK) begin
      scan_pred = last_r;
    end else begin
      scan_pred = NO_LINK;
    end
    scan_cnt = {1'b0, scan_steps_r} + 17'd1;
  end

  // Next state, memory schedule and shared unit operands
  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    page_nxt       = page_r;
    now_nxt        = now_r;
    in_use_nxt     = in_use_r;
    np_nxt         = np_r;
    pp_nxt         = pp_r;
    diff_nxt       = diff_r;
    status_nxt     = status_r;
    is_new_nxt     = is_new_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    count_nxt      = count_r;
    scan_pos_nxt   = scan_pos_r;
    scan_steps_nxt = scan_steps_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    next_req       = '0;
    prev_req       = '0;
    time_req       = '0;
    next_req.raddr = page_r;
    prev_req.raddr = page_r;
    time_req.raddr = page_r;
    alu_a          = now_r;
    alu_b          = time_rdata;

    case (state_r)
      // Sweep both link memories to the unlinked value
      S_CLEAR: begin
        next_req.we    = 1'b1;
        next_req.waddr = clr_cnt_r;
        next_req.wdata = NO_LINK;
        prev_req.we    = 1'b1;
        prev_req.waddr = clr_cnt_r;
        prev_req.wdata = NO_LINK;
        clr_cnt_nxt    = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {PAGE_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      // Take a transfer and issue the first reads
      S_IDLE: begin
        if (in_data.command == CMD_TOUCH) begin
          next_req.raddr = in_data.page_number[PAGE_W-1:0];
          prev_req.raddr = in_data.page_number[PAGE_W-1:0];
          time_req.raddr = in_data.page_number[PAGE_W-1:0];
        end else begin
          prev_req.raddr = scan_pos_r[PAGE_W-1:0];
        end
        if (accept) begin
          page_nxt   = in_data.page_number[PAGE_W-1:0];
          now_nxt    = in_data.now_time;
          in_use_nxt = in_data.page_in_use;
          status_nxt = ST_NEW;
          case (in_data.command)
            CMD_TOUCH: begin
              if (in_data.page_number >= 16'(NUM_PAGES)) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_T_CHECK;
              end
            end
            CMD_SCAN_STEP: state_nxt = S_SCAN_STEP;
            CMD_SCAN_RESTART: begin
              scan_steps_nxt = '0;
              scan_pos_nxt   = last_r;
              state_nxt      = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      // Capture links, take the age of the page
      S_T_CHECK: begin
        np_nxt   = next_rdata;
        pp_nxt   = prev_rdata;
        diff_nxt = alu_res.diff;
        if (next_rdata == NO_LINK && prev_rdata == NO_LINK) begin
          is_new_nxt = 1'b1;
          state_nxt  = S_T_LINK;
        end else begin
          is_new_nxt = 1'b0;
          state_nxt  = S_T_COMPARE;
        end
      end

      // Compare the age against the update interval
      S_T_COMPARE: begin
        alu_a = diff_r;
        alu_b = interval_r;
        if (!alu_res.borrow) begin
          if (in_use_r) begin
            status_nxt = ST_HIT;
            state_nxt  = S_T_UNLINK;
          end else begin
            status_nxt = ST_NOT_USED;
            state_nxt  = S_T_FINISH;
          end
        end else begin
          status_nxt = ST_RECENT;
          state_nxt  = S_DONE;
        end
      end

      // Close the gap the page leaves behind
      S_T_UNLINK: begin
        if (pp_r < HEAD_MARK) begin
          next_req.we    = 1'b1;
          next_req.waddr = pp_r[PAGE_W-1:0];
          next_req.wdata = np_r;
        end else if (pp_r == HEAD_MARK) begin
          first_nxt = np_r;
        end
        if (np_r < HEAD_MARK) begin
          prev_req.we    = 1'b1;
          prev_req.waddr = np_r[PAGE_W-1:0];
          prev_req.wdata = pp_r;
        end else if (np_r == TAIL_MARK) begin
          last_nxt = pp_r;
        end
        state_nxt = S_T_LINK;
      end

      // Hook the old first node behind the page
      S_T_LINK: begin
        if (first_r < HEAD_MARK) begin
          prev_req.we    = 1'b1;
          prev_req.waddr = first_r[PAGE_W-1:0];
          prev_req.wdata = {1'b0, page_r};
        end else if (first_r == TAIL_MARK) begin
          last_nxt = {1'b0, page_r};
        end
        next_req.we    = 1'b1;
        next_req.waddr = page_r;
        next_req.wdata = first_r;
        if (is_new_r) begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = S_T_FINISH;
      end

      // Place the page at the head unless it is not in use, and refresh its time stamp
      S_T_FINISH: begin
        if (status_r != ST_NOT_USED) begin
          prev_req.we    = 1'b1;
          prev_req.waddr = page_r;
          prev_req.wdata = HEAD_MARK;
          first_nxt      = {1'b0, page_r};
        end
        time_req.we    = 1'b1;
        time_req.waddr = page_r;
        time_req.wdata = now_r;
        state_nxt      = S_DONE;
      end

      // Advance the scan pointer, restart at list end or step limit
      S_SCAN_STEP: begin
        alu_a = {16'd0, limit_r};
        alu_b = {15'd0, scan_cnt};
        if (scan_pred > TAIL_MARK || scan_pred == HEAD_MARK || alu_res.borrow) begin
          scan_steps_nxt = '0;
          scan_pos_nxt   = last_r;
        end else begin
          scan_steps_nxt = scan_cnt[15:0];
          scan_pos_nxt   = scan_pred;
        end
        state_nxt = S_DONE;
      end

      // Present the result
      S_DONE: begin
        out_valid_nxt               = 1'b1;
        out_data_nxt.touch_status   = status_r;
        out_data_nxt.scan_valid     = (scan_pos_r < HEAD_MARK);
        out_data_nxt.scan_page      = (scan_pos_r < HEAD_MARK) ?
                                      scan_pos_r[11:0] : 12'd0;
        out_data_nxt.resident_count = count_r;
        state_nxt                   = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/page_lru_list_tracker.sv]
// Top level of the page recency list tracker: sequencer, link and time
// memories, shared subtractor. Depends on plt_pkg and the plt_* modules.
//
// Keeps resident pages in a doubly linked recency list held in two 4096-entry
// link memories plus a time stamp memory. After reset the block runs a
// clearing pass over the link memories with in_stall high; configuration
// writes are taken at any time. Each command then takes one transfer and
// yields one result. A touch of a listed page that moves passes the check,
// compare, unlink, link and finish states; a new page check, link and finish;
// a refresh of a page not in use check, compare and finish; a too recent page
// check and compare; a scan step the scan step state; an out of range page, a
// scan restart or the unused command go straight to the result. The link
// memories, each with one write port and registered reads, force the unlink
// and relink writes into separate cycles. One item is in flight at a time; the
// next can be taken in the cycle after the previous result has been transferred.
module page_lru_list_tracker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  plt_pkg::in_item_t             in_data,
  output logic                          in_stall,
  output logic                          out_valid,
  output plt_pkg::out_item_t            out_data,
  input  logic                          out_stall,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import plt_pkg::*;

  link_req_t         next_req, prev_req;
  time_req_t         time_req;
  logic [LINK_W-1:0] next_rdata, prev_rdata;
  logic [31:0]       time_rdata;
  logic [31:0]       alu_a, alu_b;
  alu_res_t          alu_res;

  plt_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .out_stall  (out_stall),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .next_req   (next_req),
    .prev_req   (prev_req),
    .time_req   (time_req),
    .next_rdata (next_rdata),
    .prev_rdata (prev_rdata),
    .time_rdata (time_rdata),
    .alu_a      (alu_a),
    .alu_b      (alu_b),
    .alu_res    (alu_res)
  );

  // Forward links
  plt_ram #(.DEPTH(NUM_PAGES), .WIDTH(LINK_W)) u_next_ram (
    .clk   (clk),
    .we    (next_req.we),
    .waddr (next_req.waddr),
    .wdata (next_req.wdata),
    .raddr (next_req.raddr),
    .rdata (next_rdata)
  );

  // Backward links
  plt_ram #(.DEPTH(NUM_PAGES), .WIDTH(LINK_W)) u_prev_ram (
    .clk   (clk),
    .we    (prev_req.we),
    .waddr (prev_req.waddr),
    .wdata (prev_req.wdata),
    .raddr (prev_req.raddr),
    .rdata (prev_rdata)
  );

  // Last update time per page
  plt_ram #(.DEPTH(NUM_PAGES), .WIDTH(32)) u_time_ram (
    .clk   (clk),
    .we    (time_req.we),
    .waddr (time_req.waddr),
    .wdata (time_req.wdata),
    .raddr (time_req.raddr),
    .rdata (time_rdata)
  );

  plt_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

endmodule

[hw/rtl/plt_checker.sv]
// Port-level checks for the page recency list tracker, bound to the top.
// Depends on plt_pkg.
module plt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input plt_pkg::out_item_t            out_data,
  input logic                          out_stall
);
  import plt_pkg::*;

  // Busy after every input transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken back to back");

  // A pending result blocks new input
  a_result_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // Resident count bounded by the page space
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.resident_count <= 13'(NUM_PAGES))
    else $error("resident count beyond page space");

  // Scan page reads zero off the list
  a_scan_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.scan_valid |-> out_data.scan_page == 12'd0)
    else $error("scan page set while pointer on list end");

  // Held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind page_lru_list_tracker plt_checker u_plt_checker (.*);

[dv/page_lru_list_tracker_tb.sv]
// Self-checking testbench for page_lru_list_tracker: holds its own recency list
// model and checks every result in order. Depends on plt_pkg and the RTL.
`timescale 1ns / 1ps

module page_lru_list_tracker_tb;
  import plt_pkg::*;

  localparam int NPG = NUM_PAGES;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_data = '0;
  logic in_stall;
  logic out_valid;
  out_item_t out_data;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  page_lru_list_tracker DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Recency list model state
  logic [LINK_W-1:0] fwd_link [NPG];
  logic [LINK_W-1:0] back_link [NPG];
  logic [31:0] stamp [NPG];
  logic [LINK_W-1:0] head_ptr, tail_ptr, walk_pos;
  logic [12:0] listed;
  logic [15:0] walk_steps;
  logic [31:0] min_interval;
  logic [15:0] walk_limit;

  out_item_t expected_results[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  logic [31:0] clock_now = 32'd1000;

  task automatic set_fwd(input logic [LINK_W-1:0] node, input logic [LINK_W-1:0] v);
    if (node < NPG) fwd_link[node] = v;
    else if (node == HEAD_MARK) head_ptr = v;
  endtask

  task automatic set_back(input logic [LINK_W-1:0] node, input logic [LINK_W-1:0] v);
    if (node < NPG) back_link[node] = v;
    else if (node == TAIL_MARK) tail_ptr = v;
  endtask

  task automatic link_front(input logic [LINK_W-1:0] p);
    logic [LINK_W-1:0] old;
    old = head_ptr;
    set_back(old, p);
    fwd_link[p] = old;
    back_link[p] = HEAD_MARK;
    head_ptr = p;
    listed++;
  endtask

  task automatic restart_walk();
    walk_steps = '0;
    walk_pos = tail_ptr;
  endtask

  // Advance the model by one command and queue the result it implies
  task automatic predict_command(input in_item_t it);
    out_item_t r;
    logic [LINK_W-1:0] p, a, b, pos;
    logic [16:0] cnt;
    r = '0;
    r.touch_status = ST_NEW;
    if (it.command == CMD_TOUCH) begin
      if (it.page_number >= NPG) begin
        r.touch_status = ST_RANGE;
      end else begin
        p = LINK_W'(it.page_number);
        if (fwd_link[p] == NO_LINK && back_link[p] == NO_LINK) begin
          link_front(p);
          stamp[p] = it.now_time;
          r.touch_status = ST_NEW;
        end else if (it.now_time - stamp[p] >= min_interval) begin
          r.touch_status = ST_NOT_USED;
          if (it.page_in_use) begin
            a = back_link[p];
            b = fwd_link[p];
            set_fwd(a, b);
            set_back(b, a);
            fwd_link[p] = NO_LINK;
            back_link[p] = NO_LINK;
            if (listed > 0) listed--;
            link_front(p);
            r.touch_status = ST_HIT;
          end
          stamp[p] = it.now_time;
        end else begin
          r.touch_status = ST_RECENT;
        end
      end
    end else if (it.command == CMD_SCAN_STEP) begin
      cnt = {1'b0, walk_steps} + 17'd1;
      if (walk_pos < NPG) pos = back_link[walk_pos];
      else if (walk_pos == TAIL_MARK) pos = tail_ptr;
      else pos = NO_LINK;
      walk_pos = pos;
      walk_steps = cnt[15:0];
      if (pos >= NPG + 2 || pos == HEAD_MARK || cnt > {1'b0, walk_limit}) restart_walk();
    end else if (it.command == CMD_SCAN_RESTART) begin
      restart_walk();
    end
    r.scan_valid = (walk_pos < NPG);
    r.scan_page = r.scan_valid ? walk_pos[11:0] : 12'd0;
    r.resident_count = listed;
    expected_results.push_back(r);
  endtask

  // Offer one item, hold it until the transfer, and leave valid high
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] page,
                           input logic [31:0] now, input logic use_flag);
    in_item_t it;
    bit taken;
    logic [63:0] junk;
    it.command = cmd;
    it.page_number = page;
    it.now_time = now;
    it.page_in_use = use_flag;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid = 1'b0;
      junk = {$urandom, $urandom};
      in_data = junk[$bits(in_item_t)-1:0];
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
    end
    predict_command(it);
  endtask

  // Lower valid and wait until every result has come back
  task automatic drain();
    int guard;
    @(negedge clk);
    in_valid = 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    if (expected_results.size() != 0) begin
      $display("%0t: results missing, %0d outstanding", $time, expected_results.size());
      errors++;
    end
    repeat (12) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    bit taken;
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = cfg_ready;
    end
    if (idx == CFG_UPDATE_INTERVAL) min_interval = v;
    else if (idx == CFG_SCAN_STEP_LIMIT) walk_limit = v[15:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [15:0] pick_page();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(0, 23));
    if (r < 85) return 16'($urandom_range(0, NPG - 1));
    if (r < 92) return (r[0]) ? 16'(NPG - 1) : 16'd0;
    return 16'($urandom);
  endfunction

  task automatic send_random();
    int r;
    logic [1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 55) cmd = CMD_TOUCH;
    else if (r < 88) cmd = CMD_SCAN_STEP;
    else if (r < 96) cmd = CMD_SCAN_RESTART;
    else cmd = CMD_UNUSED;
    if ($urandom_range(0, 19) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(0, 80);
    send_item(cmd, pick_page(), clock_now, ($urandom_range(0, 3) != 0));
  endtask

  task automatic test_directed();
    send_item(CMD_TOUCH, 16'd0, 32'd100, 1'b1);
    send_item(CMD_TOUCH, 16'(NPG - 1), 32'd200, 1'b1);
    send_item(CMD_TOUCH, 16'(NPG), 32'd300, 1'b1);
    send_item(CMD_TOUCH, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    send_item(CMD_TOUCH, 16'd0, 32'd300, 1'b1);
    send_item(CMD_SCAN_STEP, 16'd0, 32'd0, 1'b0);
    send_item(CMD_SCAN_STEP, 16'd0, 32'd0, 1'b0);
    send_item(CMD_SCAN_STEP, 16'd0, 32'd0, 1'b0);
    send_item(CMD_SCAN_RESTART, 16'd0, 32'd0, 1'b0);
    send_item(CMD_UNUSED, 16'h5A5A, 32'h1234_5678, 1'b1);
    send_item(CMD_TOUCH, 16'd0, 32'd30000, 1'b0);
    send_item(CMD_TOUCH, 16'd0, 32'd60000, 1'b1);
    send_item(CMD_TOUCH, 16'd7, 32'hFFFF_FFF0, 1'b1);
    send_item(CMD_TOUCH, 16'd7, 32'd24000, 1'b1);
    send_item(CMD_SCAN_STEP, 16'd0, 32'd0, 1'b0);
    write_reg(CFG_UPDATE_INTERVAL, 32'd0);
    write_reg(CFG_SCAN_STEP_LIMIT, 32'd0);
    send_item(CMD_TOUCH, 16'(NPG - 1), 32'd0, 1'b1);
    send_item(CMD_SCAN_STEP, 16'd0, 32'd0, 1'b0);
    send_item(CMD_SCAN_STEP, 16'd0, 32'd0, 1'b0);
    send_item(CMD_TOUCH, 16'd0, 32'd0, 1'b0);
  endtask

  task automatic test_random_phase(input int n, input int si, input int ri,
                                   input logic [31:0] interval, input logic [15:0] limit);
    write_reg(CFG_UPDATE_INTERVAL, interval);
    write_reg(CFG_SCAN_STEP_LIMIT, {16'd0, limit});
    send_idle = si;
    recv_idle = ri;
    repeat (n) send_random();
  endtask

  // Hold the output off long enough that the block stalls its input
  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    @(posedge clk);
    hold_cycles = 300;
    repeat (30) send_random();
  endtask

  // Receiver stall: long hold-off first, else random idling
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_idle);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.touch_status !== want.touch_status) begin
          $display("%0t: touch_status exp %0d got %0d", $time, want.touch_status,
                   out_data.touch_status);
          errors++;
        end
        if (out_data.scan_page !== want.scan_page) begin
          $display("%0t: scan_page exp %0d got %0d", $time, want.scan_page,
                   out_data.scan_page);
          errors++;
        end
        if (out_data.scan_valid !== want.scan_valid) begin
          $display("%0t: scan_valid exp %0d got %0d", $time, want.scan_valid,
                   out_data.scan_valid);
          errors++;
        end
        if (out_data.resident_count !== want.resident_count) begin
          $display("%0t: resident_count exp %0d got %0d", $time, want.resident_count,
                   out_data.resident_count);
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    for (int i = 0; i < NPG; i++) begin
      fwd_link[i] = NO_LINK;
      back_link[i] = NO_LINK;
      stamp[i] = '0;
    end
    head_ptr = TAIL_MARK;
    tail_ptr = HEAD_MARK;
    walk_pos = TAIL_MARK;
    listed = '0;
    walk_steps = '0;
    min_interval = UPDATE_INTERVAL_RST;
    walk_limit = SCAN_STEP_LIMIT_RST;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_phase(130, 12, 74, 32'd50, 16'd3);
    test_random_phase(130, 74, 12, 32'hFFFF_FFFF, 16'hFFFF);
    test_random_phase(70, 0, 0, 32'd20, 16'd1);
    test_backpressure();
    test_random_phase(70, 0, 0, UPDATE_INTERVAL_RST, SCAN_STEP_LIMIT_RST);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/plt_pkg.sv
hw/rtl/plt_ram.sv
hw/rtl/plt_alu.sv
hw/rtl/plt_seq.sv
hw/rtl/page_lru_list_tracker.sv
hw/rtl/plt_checker.sv
dv/page_lru_list_tracker_tb.sv
